// ----- rtl/tct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TCP connection tracker package
// Shared sizes, outcome codes and datapath command/status types.
// ----------------------------------------------------------------------------
package tct_pkg;
   localparam int MaxConnections = 64;
   localparam int IdxW = $clog2(MaxConnections);
   localparam int CntW = $clog2(MaxConnections + 1);

   localparam logic [15:0] EtherIpv4 = 16'h0800;
   localparam logic [7:0]  ProtoTcp  = 8'd6;

   localparam logic [2:0] OUT_IGNORED = 3'd0;
   localparam logic [2:0] OUT_NEW     = 3'd1;
   localparam logic [2:0] OUT_INIT    = 3'd2;
   localparam logic [2:0] OUT_RESP    = 3'd3;
   localparam logic [2:0] OUT_NOMATCH = 3'd4;
   localparam logic [2:0] OUT_FULL    = 3'd5;

   typedef struct packed {
      logic           load;      // capture input word
      logic           clear_wr;  // write zero entry at sweep index
      logic           scan_rd;   // issue a table read at scan index
      logic           create;    // write new entry
      logic           update;    // write updated counters for hit entry
      logic           finish;    // load the output register
   } cmd_type;

   typedef struct packed {
      logic           is_ipv4;
      logic           is_tcp;
      logic           is_syn;
      logic           full;
      logic           fwd_hit;
      logic           rev_hit;
      logic           scan_last; // scanned entry is the last used one
      logic           none_used;
      logic           sweep_done;
   } sts_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/tct_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TCP connection tracker datapath
// Input capture, payload length, connection table memory and result register.
// ----------------------------------------------------------------------------
module tct_datapath
   import tct_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output sts_type           sts,
   input  wire logic [151:0] in_word,
   output logic      [127:0] out_word
);
   // Table row: sip, dip, sport, dport, ipk, rpk, iby, rby.
   typedef struct packed {
      logic [31:0] sip;
      logic [31:0] dip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] ipk;
      logic [31:0] rpk;
      logic [31:0] iby;
      logic [31:0] rby;
   } row_type;

   row_type mem [MaxConnections];
   row_type rd_ff;

   logic [151:0]    hdr_ff;
   logic [15:0]     plen_ff, plen_in;
   logic [CntW-1:0] used_ff, used_in;
   logic [31:0]     pnum_ff, pnum_in;
   logic [IdxW-1:0] idx_ff, idx_in, hit_ff, hit_in;
   logic [CntW-1:0] sweep_ff, sweep_in;
   logic [127:0]    out_ff;

   logic [15:0] ether, sport, dport, total;
   logic [7:0]  proto, flags;
   logic [31:0] sip, dip;
   logic [3:0]  ihw, thw;
   logic [6:0]  hdr_len;
   row_type     wr_row, upd_row;
   logic [31:0] dpk, dby;

   assign ether = hdr_ff[15:0];
   assign proto = hdr_ff[23:16];
   assign sip   = hdr_ff[55:24];
   assign dip   = hdr_ff[87:56];
   assign sport = hdr_ff[103:88];
   assign dport = hdr_ff[119:104];
   assign flags = hdr_ff[127:120];
   assign total = hdr_ff[143:128];
   assign ihw   = hdr_ff[147:144];
   assign thw   = hdr_ff[151:148];
   assign hdr_len = {1'b0, ihw, 2'b00} + {1'b0, thw, 2'b00};

   always_comb begin
      plen_in = (total > {9'd0, hdr_len}) ? total - {9'd0, hdr_len} : 16'd0;
   end

   assign sts.is_ipv4    = ether == EtherIpv4;
   assign sts.is_tcp     = proto == ProtoTcp;
   assign sts.is_syn     = flags[3:0] == 4'h2 && flags[7:4] != 4'h1;
   assign sts.full       = used_ff == CntW'(MaxConnections);
   assign sts.none_used  = used_ff == '0;
   assign sts.scan_last  = {1'b0, hit_ff} == used_ff - CntW'(1);
   assign sts.fwd_hit    = rd_ff.sip == sip && rd_ff.dip == dip &&
                           rd_ff.sport == sport && rd_ff.dport == dport;
   assign sts.rev_hit    = rd_ff.dip == sip && rd_ff.sip == dip &&
                           rd_ff.dport == sport && rd_ff.sport == dport;
   assign sts.sweep_done = sweep_ff == CntW'(MaxConnections);

   always_comb begin
      upd_row = rd_ff;
      if (sts.fwd_hit) begin
         upd_row.ipk = sat_add(rd_ff.ipk, 32'd1);
         upd_row.iby = sat_add(rd_ff.iby, {16'd0, plen_ff});
      end else begin
         upd_row.rpk = sat_add(rd_ff.rpk, 32'd1);
         upd_row.rby = sat_add(rd_ff.rby, {16'd0, plen_ff});
      end
      wr_row = '0;
      if (cmd.create) begin
         wr_row.sip = sip;
         wr_row.dip = dip;
         wr_row.sport = sport;
         wr_row.dport = dport;
         wr_row.ipk = 32'd1;
      end else if (cmd.update) begin
         wr_row = upd_row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[sweep_ff[IdxW-1:0]] <= '0;
      end else if (cmd.create) begin
         mem[used_ff[IdxW-1:0]] <= wr_row;
      end else if (cmd.update) begin
         mem[hit_ff] <= wr_row;
      end
      if (cmd.scan_rd) begin
         rd_ff <= mem[idx_ff];
      end
   end

   // Each read remembers the index it fetched and moves on to the next one.
   always_comb begin
      used_in  = used_ff;
      pnum_in  = pnum_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      sweep_in = sweep_ff;
      if (cmd.clear_wr) sweep_in = sweep_ff + CntW'(1);
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.scan_rd) begin
         idx_in = idx_ff + IdxW'(1);
      end
      if (cmd.scan_rd) begin
         hit_in = idx_ff;
      end
      if (cmd.create) used_in = used_ff + CntW'(1);
      if (cmd.finish && sts.is_ipv4) pnum_in = sat_add(pnum_ff, 32'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         pnum_ff  <= '0;
         sweep_ff <= '0;
      end else begin
         used_ff  <= used_in;
         pnum_ff  <= pnum_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hdr_ff <= in_word;
      end
      idx_ff  <= idx_in;
      hit_ff  <= hit_in;
      plen_ff <= plen_in;
   end

   // Result word: outcome, index, packet number, packets, bytes, payload.
   logic [2:0]  oc;
   logic [5:0]  oix;
   logic [15:0] opl;
   always_comb begin
      oc  = OUT_IGNORED;
      oix = '0;
      dpk = '0;
      dby = '0;
      opl = '0;
      if (sts.is_ipv4 && sts.is_tcp) begin
         opl = plen_in;
         if (sts.is_syn) begin
            if (sts.full) begin
               oc = OUT_FULL;
            end else begin
               oc  = OUT_NEW;
               oix = 6'(used_ff);
               dpk = 32'd1;
            end
         end else if (cmd.update) begin
            oc  = sts.fwd_hit ? OUT_INIT : OUT_RESP;
            oix = 6'(hit_ff);
            dpk = sts.fwd_hit ? upd_row.ipk : upd_row.rpk;
            dby = sts.fwd_hit ? upd_row.iby : upd_row.rby;
         end else begin
            oc = OUT_NOMATCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_ff <= {7'd0, opl, dby, dpk, pnum_in, oix, oc};
      end
   end
   assign out_word = out_ff;
endmodule
`default_nettype wire

// ----- rtl/tct_control.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TCP connection tracker controller
// Sequences the clearing sweep, header capture, table scan and result hand-off.
// ----------------------------------------------------------------------------
module tct_control
   import tct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire sts_type sts,
   output cmd_type      cmd,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready
);
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DEC   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       vld_ff, vld_in;

   // A new word is taken in idle once the result slot is empty or being emptied.
   assign req_tready = state_ff == S_IDLE && (!vld_ff || rsp_tready);
   assign rsp_tvalid = vld_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      vld_in   = vld_ff && !rsp_tready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = !sts.sweep_done;
            if (sts.sweep_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (!sts.is_ipv4 || !sts.is_tcp || sts.is_syn || sts.none_used) begin
               cmd.create = sts.is_ipv4 && sts.is_tcp && sts.is_syn && !sts.full;
               cmd.finish = 1'b1;
               vld_in     = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_READ: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_CMP;
         end
         S_CMP: begin
            if (sts.fwd_hit || sts.rev_hit || sts.scan_last) begin
               cmd.update = sts.fwd_hit || sts.rev_hit;
               cmd.finish = 1'b1;
               vld_in     = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/tcp_connection_tracker_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TCP connection tracker core
// Tracks TCP connections by four-tuple and counts packets and bytes per side.
// SYN, ignored and empty-table words finish in the decode state; a lookup
// reads and compares one entry at a time via the table's single read port.
// One word in flight at a time. After reset a clearing pass writes all 64
// entries before the first word is accepted.
// ----------------------------------------------------------------------------
module tcp_connection_tracker_core
   import tct_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // eth_type, ip_proto, src_ip, dst_ip, src_port, dst_port, tcp_flags,
   // ip_total_length, ip_header_words, tcp_header_words
   input  wire logic [151:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // outcome, connection_index, packet_number, direction_packets,
   // direction_bytes, payload_length, zero fill
   output logic      [127:0] rsp_tdata
);
   cmd_type      cmd;
   sts_type      sts;
   logic [127:0] out_word;

   tct_control u_control (
      .clock, .reset, .sts, .cmd,
      .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready
   );

   tct_datapath u_datapath (
      .clock, .reset, .cmd, .sts,
      .in_word (req_tdata),
      .out_word
   );

   assign rsp_tdata = out_word;
endmodule
`default_nettype wire
